// File: rtl/ipmp_pkg.sv
package ipmp_pkg;

  // APB register window
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;

  // Fixed-point scaling of the three terms
  localparam int unsigned P_SHIFT = 12;
  localparam int unsigned I_SHIFT = 14;
  localparam int unsigned D_SHIFT = 12;

  // Register reset values
  localparam logic [14:0]        GAIN_RST       = 15'd0;
  localparam logic signed [15:0] INT_UPPER_RST  = 16'sd32767;
  localparam logic signed [15:0] INT_LOWER_RST  = 16'sd0;
  localparam logic signed [15:0] STEP_UPPER_RST = 16'sd50;
  localparam logic signed [15:0] STEP_LOWER_RST = -16'sd50;
  localparam logic [9:0]         CEILING_RST    = 10'd800;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INT_UPPER  = 3'd3,
    REG_INT_LOWER  = 3'd4,
    REG_STEP_UPPER = 3'd5,
    REG_STEP_LOWER = 3'd6,
    REG_CEILING    = 3'd7
  } reg_idx_t;

  // Input action codes
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic              action;
    logic [14:0]       target_magnitude;
    logic              forward;
    logic signed [15:0] measured_speed;
    logic signed [15:0] measured_accel;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]         drive_power;
    logic signed [15:0] integral_now;
  } out_beat_t;

  typedef struct packed {
    logic [14:0]        gain_p;
    logic [14:0]        gain_i;
    logic [14:0]        gain_d;
    logic signed [15:0] integral_upper;
    logic signed [15:0] integral_lower;
    logic signed [15:0] step_upper;
    logic signed [15:0] step_lower;
    logic [9:0]         power_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] integ;
    logic [9:0]         power;
  } loop_state_t;

endpackage

// File: rtl/ipmp_regs.sv
module ipmp_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ipmp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ipmp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ipmp_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output ipmp_pkg::cfg_t                    cfg_o
);

  ipmp_pkg::cfg_t     cfg_r;
  ipmp_pkg::cfg_t     cfg_nxt;
  ipmp_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = ipmp_pkg::reg_idx_t'(cfg_paddr[ipmp_pkg::CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ipmp_pkg::REG_GAIN_P:     cfg_nxt.gain_p         = cfg_pwdata[14:0];
        ipmp_pkg::REG_GAIN_I:     cfg_nxt.gain_i         = cfg_pwdata[14:0];
        ipmp_pkg::REG_GAIN_D:     cfg_nxt.gain_d         = cfg_pwdata[14:0];
        ipmp_pkg::REG_INT_UPPER:  cfg_nxt.integral_upper = cfg_pwdata[15:0];
        ipmp_pkg::REG_INT_LOWER:  cfg_nxt.integral_lower = cfg_pwdata[15:0];
        ipmp_pkg::REG_STEP_UPPER: cfg_nxt.step_upper     = cfg_pwdata[15:0];
        ipmp_pkg::REG_STEP_LOWER: cfg_nxt.step_lower     = cfg_pwdata[15:0];
        ipmp_pkg::REG_CEILING:    cfg_nxt.power_ceiling  = cfg_pwdata[9:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= ipmp_pkg::GAIN_RST;
      cfg_r.gain_i         <= ipmp_pkg::GAIN_RST;
      cfg_r.gain_d         <= ipmp_pkg::GAIN_RST;
      cfg_r.integral_upper <= ipmp_pkg::INT_UPPER_RST;
      cfg_r.integral_lower <= ipmp_pkg::INT_LOWER_RST;
      cfg_r.step_upper     <= ipmp_pkg::STEP_UPPER_RST;
      cfg_r.step_lower     <= ipmp_pkg::STEP_LOWER_RST;
      cfg_r.power_ceiling  <= ipmp_pkg::CEILING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux, zero-extended raw register bits
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      ipmp_pkg::REG_GAIN_P:     cfg_prdata = {17'd0, cfg_r.gain_p};
      ipmp_pkg::REG_GAIN_I:     cfg_prdata = {17'd0, cfg_r.gain_i};
      ipmp_pkg::REG_GAIN_D:     cfg_prdata = {17'd0, cfg_r.gain_d};
      ipmp_pkg::REG_INT_UPPER:  cfg_prdata = {16'd0, cfg_r.integral_upper};
      ipmp_pkg::REG_INT_LOWER:  cfg_prdata = {16'd0, cfg_r.integral_lower};
      ipmp_pkg::REG_STEP_UPPER: cfg_prdata = {16'd0, cfg_r.step_upper};
      ipmp_pkg::REG_STEP_LOWER: cfg_prdata = {16'd0, cfg_r.step_lower};
      ipmp_pkg::REG_CEILING:    cfg_prdata = {22'd0, cfg_r.power_ceiling};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

// File: rtl/ipmp_calc.sv
module ipmp_calc (
  input  ipmp_pkg::in_beat_t    beat_i,
  input  ipmp_pkg::cfg_t        cfg_i,
  input  ipmp_pkg::loop_state_t state_i,
  output ipmp_pkg::loop_state_t state_o
);

  localparam int unsigned PH = ipmp_pkg::P_SHIFT + 15;
  localparam int unsigned IH = ipmp_pkg::I_SHIFT + 15;
  localparam int unsigned DH = ipmp_pkg::D_SHIFT + 15;

  logic signed [15:0] target;
  logic signed [15:0] err;
  logic signed [15:0] integ_raw;
  logic signed [16:0] neg_upper;
  logic signed [16:0] neg_lower;
  logic signed [15:0] integ_hi;
  logic signed [15:0] integ_cl;
  logic signed [15:0] gp;
  logic signed [15:0] gi;
  logic signed [15:0] gd;
  logic signed [31:0] prod_p;
  logic signed [31:0] prod_i;
  logic signed [31:0] prod_d;
  logic signed [15:0] sum16;
  logic signed [15:0] adj_dir;
  logic signed [15:0] adj_hi;
  logic signed [15:0] adj;
  logic signed [17:0] pwr;
  logic signed [17:0] ceil_s;

  // Signed target and wrapped error (magnitude is nonzero on this path)
  assign target    = beat_i.forward ? {1'b0, beat_i.target_magnitude}
                                    : -{1'b0, beat_i.target_magnitude};
  assign err       = target - beat_i.measured_speed;
  assign integ_raw = state_i.integ + err;

  // Integral clamp; negated bounds kept exact at 17 bits for the compare
  assign neg_upper = -{cfg_i.integral_upper[15], cfg_i.integral_upper};
  assign neg_lower = -{cfg_i.integral_lower[15], cfg_i.integral_lower};

  always_comb begin
    if (beat_i.forward) begin
      integ_hi = (integ_raw > cfg_i.integral_upper) ? cfg_i.integral_upper : integ_raw;
      integ_cl = (integ_hi < cfg_i.integral_lower) ? cfg_i.integral_lower : integ_hi;
    end else begin
      integ_hi = ($signed({integ_raw[15], integ_raw}) < neg_upper) ? neg_upper[15:0]
                                                                  : integ_raw;
      integ_cl = ($signed({integ_hi[15], integ_hi}) > neg_lower) ? neg_lower[15:0]
                                                                : integ_hi;
    end
  end

  // Three parallel products; only the low 16 bits of the shifted sum survive
  assign gp     = {1'b0, cfg_i.gain_p};
  assign gi     = {1'b0, cfg_i.gain_i};
  assign gd     = {1'b0, cfg_i.gain_d};
  assign prod_p = err * gp;
  assign prod_i = integ_cl * gi;
  assign prod_d = beat_i.measured_accel * gd;
  assign sum16  = prod_p[PH:ipmp_pkg::P_SHIFT] + prod_i[IH:ipmp_pkg::I_SHIFT]
                - prod_d[DH:ipmp_pkg::D_SHIFT];

  // Direction, then step limits (upper first, lower wins if crossed)
  assign adj_dir = beat_i.forward ? sum16 : -sum16;
  assign adj_hi  = (adj_dir > cfg_i.step_upper) ? cfg_i.step_upper : adj_dir;
  assign adj     = (adj_hi < cfg_i.step_lower) ? cfg_i.step_lower : adj_hi;

  // Power update held to 0..ceiling
  assign pwr    = $signed({8'd0, state_i.power}) + 18'(adj);
  assign ceil_s = $signed({8'd0, cfg_i.power_ceiling});

  always_comb begin
    state_o = state_i;
    priority if (beat_i.action == ipmp_pkg::ACT_CLEAR) begin
      state_o.integ = '0;
    end else if (beat_i.target_magnitude == '0) begin
      state_o.power = '0;
    end else begin
      state_o.integ = integ_cl;
      priority if (pwr < 0) begin
        state_o.power = '0;
      end else if (pwr > ceil_s) begin
        state_o.power = cfg_i.power_ceiling;
      end else begin
        state_o.power = pwr[9:0];
      end
    end
  end

endmodule

// File: rtl/incremental_pid_motor_power.sv
// An accepted input beat enters the input stage, then the result register.
// Throughput: one beat per cycle unless out_stall holds; the integral and power
// feedback through state_r and the multiply/clamp path sets the clock limit.
// Reset (rst_n low, synchronous): both stages empty, integral and power zero,
// configuration registers return to their defaults.
module incremental_pid_motor_power (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ipmp_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ipmp_pkg::out_beat_t               out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ipmp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ipmp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ipmp_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  ipmp_pkg::cfg_t        cfg;
  ipmp_pkg::loop_state_t state_r;
  ipmp_pkg::loop_state_t state_nxt;
  ipmp_pkg::in_beat_t    s1_data_r;
  ipmp_pkg::out_beat_t   out_data_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  advance;
  logic                  in_take;

  ipmp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  ipmp_calc u_calc (
    .beat_i  (s1_data_r),
    .cfg_i   (cfg),
    .state_i (state_r),
    .state_o (state_nxt)
  );

  // Handshake: input stage moves to the result register when that is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.drive_power  <= state_nxt.power;
      out_data_r.integral_now <= state_nxt.integ;
    end
  end

  // Checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input stage");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("loop state changed without a beat");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_valid_r && out_data_r.drive_power == state_r.power &&
                 out_data_r.integral_now == state_r.integ))
    else $error("result beat disagrees with loop state");

endmodule
